FILE: sv/assert_macros.svh
// Assertion helpers for the capture parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: sv/php_pkg.sv
`default_nettype none

package php_pkg;

  localparam int unsigned MAX_CAPTURE = 65536;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  localparam logic [31:0] PCAP_MAGIC     = 32'ha1b2c3d4;
  localparam logic [31:0] LINKTYPE_ETH   = 32'd1;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [13:0] FRAG_MASK      = 14'h3fff;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SHORT_GLOBAL = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_BAD_LINK     = 3'd3;
  localparam logic [2:0] ST_CAPLEN       = 3'd4;
  localparam logic [2:0] ST_TRUNC        = 3'd5;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] packet_number;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_tcp;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [2:0]  status;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic first;
    logic second;
  } fifo_wr_t;

endpackage

`default_nettype wire

FILE: sv/pcap_ipv4_header_parser.sv
// Flow: an accepted byte is registered and parsed once the result queue has room; its results
// are written into the result queue and offered at the output from there.
// Throughput: one byte per cycle while the result queue has room; a byte that yields a
// summary and an end-of-file status writes two items into a four-entry result queue.
// Reset: rst_ni low clears all parse state, the result queue and start_packet at once.
`default_nettype none

module pcap_ipv4_header_parser #(
  parameter int unsigned MaxCapture = php_pkg::MAX_CAPTURE
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_packet_we_i,
  input  wire logic [31:0] start_packet_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [31:0]      packet_number_o,
  output logic [31:0]      src_ip_o,
  output logic [31:0]      dst_ip_o,
  output logic [15:0]      src_port_o,
  output logic [15:0]      dst_port_o,
  output logic             is_tcp_o,
  output logic [15:0]      payload_offset_o,
  output logic [15:0]      payload_length_o,
  output logic [2:0]       status_o,
  output logic             last_of_run_o
);
  import php_pkg::*;

  localparam int unsigned CntW = $clog2(MaxCapture + 1);

  localparam logic [1:0] PhGlobal = 2'd0;
  localparam logic [1:0] PhRecHdr = 2'd1;
  localparam logic [1:0] PhData   = 2'd2;
  localparam logic [1:0] PhError  = 2'd3;

  logic             in_v_q, in_v_d;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [31:0]      start_q;

  logic [1:0]       phase_q, phase_d;
  logic [CntW-1:0]  byte_cnt_q, byte_cnt_d, cnt_inc;
  logic [31:0]      snap_len_q, snap_len_d;
  logic [31:0]      hdr_word_q, hdr_word_d;
  logic [CntW-1:0]  cap_len_q, cap_len_d;
  logic [31:0]      rec_cnt_q, rec_cnt_d;
  logic [5:0]       ip_hlen_q, ip_hlen_d;
  logic [15:0]      ip_tlen_q, ip_tlen_d;
  logic             eth_ok_q, eth_ok_d;
  logic             frag_q, frag_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_ip_q, src_ip_d;
  logic [31:0]      dst_ip_q, dst_ip_d;
  logic [31:0]      ports_q, ports_d;
  logic [6:0]       l4_hlen_q, l4_hlen_d;
  logic [2:0]       err_q, err_d;

  logic             go;
  logic             done;
  logic [31:0]      hw_le, hw_be;
  logic [6:0]       l4base_cur, port_at, l4len_at;
  logic [6:0]       l4base, l4len;
  logic [7:0]       need;
  logic             is_tcp, is_udp, skip, short_rec, summary;
  logic [2:0]       eof_status;
  res_t             sum_res, stat_res;
  fifo_wr_t         fifo_wr;
  logic             fifo_room;
  res_t             out_res;

  assign go         = in_v_q && fifo_room;
  assign in_ready_o = !in_v_q || go;
  assign hw_le      = {byte_q, hdr_word_q[31:8]};
  assign hw_be      = {hdr_word_q[23:0], byte_q};
  assign cnt_inc    = byte_cnt_q + CntW'(1);

  always_comb begin
    in_v_d = in_v_q;
    if (in_valid_i && in_ready_o) begin
      in_v_d = 1'b1;
    end else if (go) begin
      in_v_d = 1'b0;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    snap_len_d = snap_len_q;
    hdr_word_d = hdr_word_q;
    cap_len_d  = cap_len_q;
    rec_cnt_d  = rec_cnt_q;
    ip_hlen_d  = ip_hlen_q;
    ip_tlen_d  = ip_tlen_q;
    eth_ok_d   = eth_ok_q;
    frag_d     = frag_q;
    proto_d    = proto_q;
    src_ip_d   = src_ip_q;
    dst_ip_d   = dst_ip_q;
    ports_d    = ports_q;
    l4_hlen_d  = l4_hlen_q;
    err_d      = err_q;
    done       = 1'b0;
    l4base_cur = 7'd14 + {1'b0, ip_hlen_q};
    port_at    = 7'd17;
    l4len_at   = 7'd26;

    if (go) begin
      unique case (phase_q)
        PhGlobal: begin
          hdr_word_d = hw_le;
          if (byte_cnt_q == CntW'(3) && hw_le != PCAP_MAGIC) begin
            err_d = ST_BAD_MAGIC;
          end
          if (byte_cnt_q == CntW'(19)) begin
            snap_len_d = hw_le;
          end
          byte_cnt_d = cnt_inc;
          if (cnt_inc == CntW'(24)) begin
            if (err_d == ST_OK && hw_le != LINKTYPE_ETH) begin
              err_d = ST_BAD_LINK;
            end
            phase_d    = (err_d != ST_OK) ? PhError : PhRecHdr;
            byte_cnt_d = '0;
            hdr_word_d = '0;
          end
        end
        PhRecHdr: begin
          hdr_word_d = hw_le;
          if (byte_cnt_q == CntW'(11)) begin
            if (hw_le > snap_len_q || hw_le > 32'(MaxCapture)) begin
              err_d = ST_CAPLEN;
            end else begin
              cap_len_d = hw_le[CntW-1:0];
            end
          end
          byte_cnt_d = cnt_inc;
          if (cnt_inc == CntW'(16)) begin
            if (rec_cnt_q != '1) begin
              rec_cnt_d = rec_cnt_q + 32'd1;
            end
            byte_cnt_d = '0;
            hdr_word_d = '0;
            ip_hlen_d  = '0;
            ip_tlen_d  = '0;
            eth_ok_d   = 1'b0;
            frag_d     = 1'b0;
            proto_d    = '0;
            src_ip_d   = '0;
            dst_ip_d   = '0;
            ports_d    = '0;
            l4_hlen_d  = '0;
            if (err_d != ST_OK) begin
              phase_d = PhError;
            end else if (cap_len_d == '0) begin
              done = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          hdr_word_d = hw_be;
          if (byte_cnt_q == CntW'(13) && hw_be[15:0] == ETHERTYPE_IPV4) begin
            eth_ok_d = 1'b1;
          end
          if (byte_cnt_q == CntW'(14)) begin
            ip_hlen_d = {byte_q[3:0], 2'b00};
          end
          if (byte_cnt_q == CntW'(17)) begin
            ip_tlen_d = hw_be[15:0];
          end
          if (byte_cnt_q == CntW'(21) && (hw_be[13:0] & FRAG_MASK) != '0) begin
            frag_d = 1'b1;
          end
          if (byte_cnt_q == CntW'(23)) begin
            proto_d = byte_q;
          end
          if (byte_cnt_q == CntW'(29)) begin
            src_ip_d = hw_be;
          end
          if (byte_cnt_q == CntW'(33)) begin
            dst_ip_d = hw_be;
          end
          l4base_cur = 7'd14 + {1'b0, ip_hlen_d};
          port_at    = l4base_cur + 7'd3;
          l4len_at   = l4base_cur + 7'd12;
          if (byte_cnt_q == CntW'(port_at)) begin
            ports_d = hw_be;
          end
          if (byte_cnt_q == CntW'(l4len_at)) begin
            l4_hlen_d = {1'b0, byte_q[7:4], 2'b00};
          end
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= cap_len_q) begin
            done = 1'b1;
          end
        end
        PhError: begin
        end
      endcase
    end

    if (done) begin
      phase_d    = PhRecHdr;
      byte_cnt_d = '0;
      hdr_word_d = '0;
    end

    // record summary, from the state as it stands after this byte
    l4base    = 7'd14 + {1'b0, ip_hlen_d};
    is_tcp    = (proto_d == PROTO_TCP);
    is_udp    = (proto_d == PROTO_UDP);
    l4len     = is_tcp ? l4_hlen_d : 7'd8;
    need      = {1'b0, l4base} + (is_tcp ? ((l4_hlen_d > 7'd20) ? {1'b0, l4_hlen_d} : 8'd20)
                                         : 8'd8);
    if (need < 8'd34) begin
      need = 8'd34;
    end
    short_rec = (32'(cap_len_d) < 32'(need));
    skip      = (start_q != '0) && (rec_cnt_d < start_q);
    summary   = done && !skip && eth_ok_d && !frag_d && (is_tcp || is_udp) && !short_rec;

    sum_res.kind           = KIND_SUMMARY;
    sum_res.packet_number  = rec_cnt_d;
    sum_res.src_ip         = src_ip_d;
    sum_res.dst_ip         = dst_ip_d;
    sum_res.src_port       = ports_d[31:16];
    sum_res.dst_port       = ports_d[15:0];
    sum_res.is_tcp         = is_tcp;
    sum_res.payload_offset = 16'({1'b0, l4base} + {1'b0, l4len});
    sum_res.payload_length = ip_tlen_d - 16'(ip_hlen_d) - 16'(l4len);
    sum_res.status         = ST_OK;
    sum_res.last_of_run    = !last_q;

    unique case (phase_d)
      PhGlobal: eof_status = ST_SHORT_GLOBAL;
      PhRecHdr: eof_status = ST_OK;
      PhData:   eof_status = ST_TRUNC;
      PhError:  eof_status = err_d;
    endcase

    stat_res.kind           = KIND_STATUS;
    stat_res.packet_number  = rec_cnt_d;
    stat_res.src_ip         = '0;
    stat_res.dst_ip         = '0;
    stat_res.src_port       = '0;
    stat_res.dst_port       = '0;
    stat_res.is_tcp         = 1'b0;
    stat_res.payload_offset = '0;
    stat_res.payload_length = '0;
    stat_res.status         = eof_status;
    stat_res.last_of_run    = 1'b1;

    fifo_wr.first  = go && (summary || last_q);
    fifo_wr.second = go && summary && last_q;

    // end of file: restart from the global header
    if (go && last_q) begin
      phase_d    = PhGlobal;
      byte_cnt_d = '0;
      snap_len_d = '0;
      hdr_word_d = '0;
      cap_len_d  = '0;
      rec_cnt_d  = '0;
      ip_hlen_d  = '0;
      ip_tlen_d  = '0;
      eth_ok_d   = 1'b0;
      frag_d     = 1'b0;
      proto_d    = '0;
      src_ip_d   = '0;
      dst_ip_d   = '0;
      ports_d    = '0;
      l4_hlen_d  = '0;
      err_d      = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      start_q    <= '0;
      phase_q    <= PhGlobal;
      byte_cnt_q <= '0;
      snap_len_q <= '0;
      hdr_word_q <= '0;
      cap_len_q  <= '0;
      rec_cnt_q  <= '0;
      ip_hlen_q  <= '0;
      ip_tlen_q  <= '0;
      eth_ok_q   <= 1'b0;
      frag_q     <= 1'b0;
      proto_q    <= '0;
      src_ip_q   <= '0;
      dst_ip_q   <= '0;
      ports_q    <= '0;
      l4_hlen_q  <= '0;
      err_q      <= ST_OK;
    end else begin
      in_v_q     <= in_v_d;
      if (start_packet_we_i) begin
        start_q <= start_packet_i;
      end
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      snap_len_q <= snap_len_d;
      hdr_word_q <= hdr_word_d;
      cap_len_q  <= cap_len_d;
      rec_cnt_q  <= rec_cnt_d;
      ip_hlen_q  <= ip_hlen_d;
      ip_tlen_q  <= ip_tlen_d;
      eth_ok_q   <= eth_ok_d;
      frag_q     <= frag_d;
      proto_q    <= proto_d;
      src_ip_q   <= src_ip_d;
      dst_ip_q   <= dst_ip_d;
      ports_q    <= ports_d;
      l4_hlen_q  <= l4_hlen_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  php_result_fifo #(
    .Depth(RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (fifo_wr),
    .wr_first_i (summary ? sum_res : stat_res),
    .wr_second_i(stat_res),
    .room_o     (fifo_room),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (out_res)
  );

  assign kind_o           = out_res.kind;
  assign packet_number_o  = out_res.packet_number;
  assign src_ip_o         = out_res.src_ip;
  assign dst_ip_o         = out_res.dst_ip;
  assign src_port_o       = out_res.src_port;
  assign dst_port_o       = out_res.dst_port;
  assign is_tcp_o         = out_res.is_tcp;
  assign payload_offset_o = out_res.payload_offset;
  assign payload_length_o = out_res.payload_length;
  assign status_o         = out_res.status;
  assign last_of_run_o    = out_res.last_of_run;

endmodule

`default_nettype wire

FILE: sv/php_result_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module php_result_fifo #(
  parameter int unsigned Depth = php_pkg::RES_FIFO_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire php_pkg::fifo_wr_t wr_i,
  input  wire php_pkg::res_t   wr_first_i,
  input  wire php_pkg::res_t   wr_second_i,
  output logic                 room_o,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output php_pkg::res_t        rd_data_o
);
  import php_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = AddrW + 1;

  res_t              mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   n_wr;
  logic              pop;

  assign wr_ptr_nx  = wr_ptr_q + AddrW'(1);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign room_o     = (cnt_q <= CntW'(Depth - 2));
  assign pop        = rd_valid_o && rd_ready_i;
  assign n_wr       = CntW'(wr_i.first) + CntW'(wr_i.second);

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_wr[AddrW-1:0];
    rd_ptr_d = pop ? rd_ptr_q + AddrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + n_wr - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.first) begin
      mem_q[wr_ptr_q] <= wr_first_i;
    end
    if (wr_i.second) begin
      mem_q[wr_ptr_nx] <= wr_second_i;
    end
  end

  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth), "result queue count beyond depth")
  `ASSERT_AT(a_second_after_first, clk_i, rst_ni, wr_i.second |-> wr_i.first, "second write without first")
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, wr_i.first && !room_o, "write into full result queue")
  `ASSERT_AT(a_pop_drains, clk_i, rst_ni, (pop && !wr_i.first) |=> (cnt_q == $past(cnt_q) - CntW'(1)), "pop did not drain queue")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import php_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned BytesPerPhase = 420;
  localparam int unsigned SummariesPerPhase = 15;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } capture_byte_t;

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_REC_HEADER,
    PH_REC_DATA,
    PH_HALTED
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_packet_we_i = 1'b0;
  logic [31:0] start_packet_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [31:0] packet_number_o;
  logic [31:0] src_ip_o;
  logic [31:0] dst_ip_o;
  logic [15:0] src_port_o;
  logic [15:0] dst_port_o;
  logic        is_tcp_o;
  logic [15:0] payload_offset_o;
  logic [15:0] payload_length_o;
  logic [2:0]  status_o;
  logic        last_of_run_o;

  always #1 clk_i = ~clk_i;

  pcap_ipv4_header_parser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_packet_we_i(start_packet_we_i),
    .start_packet_i   (start_packet_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .packet_number_o  (packet_number_o),
    .src_ip_o         (src_ip_o),
    .dst_ip_o         (dst_ip_o),
    .src_port_o       (src_port_o),
    .dst_port_o       (dst_port_o),
    .is_tcp_o         (is_tcp_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .status_o         (status_o),
    .last_of_run_o    (last_of_run_o)
  );

  // Parser copy
  logic [31:0]  start_packet_q;
  parse_phase_e ph;
  logic [16:0]  byte_idx;
  logic [31:0]  snaplen_q;
  logic [31:0]  hdr_word;
  logic [16:0]  caplen_q;
  logic [31:0]  rec_number;
  logic [5:0]   ihl_bytes;
  logic [15:0]  total_len;
  logic [7:0]   proto_q;
  logic         eth_ipv4;
  logic         is_fragment;
  logic [31:0]  src_q;
  logic [31:0]  dst_q;
  logic [31:0]  ports_q;
  logic [6:0]   l4_len_q;
  logic [2:0]   err_q;

  res_t expected_results[$];

  capture_byte_t pending_bytes[$];
  logic [7:0]    file_bytes[$];
  int unsigned   frame_base, frame_len;
  int unsigned   queued_bytes, files_queued, planned_summaries;

  int unsigned fail_count, bytes_taken, summaries_checked, statuses_checked;
  int unsigned cycle_count, held_cycles;
  bit          in_fire;

  function automatic void clear_frame();
    ihl_bytes = '0;
    total_len = '0;
    proto_q = '0;
    eth_ipv4 = 1'b0;
    is_fragment = 1'b0;
    src_q = '0;
    dst_q = '0;
    ports_q = '0;
    l4_len_q = '0;
  endfunction

  function automatic void clear_parse();
    ph = PH_GLOBAL;
    byte_idx = '0;
    snaplen_q = '0;
    hdr_word = '0;
    caplen_q = '0;
    rec_number = '0;
    err_q = ST_OK;
    clear_frame();
  endfunction

  function automatic bit summarise_record(output res_t r);
    int unsigned l4base, l4len, need;
    bit          tcp;
    r = '0;
    l4base = 14 + ihl_bytes;
    if (start_packet_q != 0 && rec_number < start_packet_q) return 0;
    if (!eth_ipv4 || is_fragment) return 0;
    if (proto_q == PROTO_TCP) begin
      tcp = 1'b1;
      l4len = l4_len_q;
      need = l4base + ((l4len > 20) ? l4len : 20);
    end else if (proto_q == PROTO_UDP) begin
      tcp = 1'b0;
      l4len = 8;
      need = l4base + 8;
    end else begin
      return 0;
    end
    if (need < 34) need = 34;
    if (caplen_q < need) return 0;
    r.kind = KIND_SUMMARY;
    r.packet_number = rec_number;
    r.src_ip = src_q;
    r.dst_ip = dst_q;
    r.src_port = ports_q[31:16];
    r.dst_port = ports_q[15:0];
    r.is_tcp = tcp;
    r.payload_offset = 16'(l4base + l4len);
    r.payload_length = 16'(total_len - ihl_bytes - l4len);
    r.status = ST_OK;
    return 1;
  endfunction

  function automatic void take_frame_byte(logic [7:0] b);
    int unsigned o, l4base;
    o = byte_idx;
    hdr_word = {hdr_word[23:0], b};
    if (o == 13 && hdr_word[15:0] == ETHERTYPE_IPV4) eth_ipv4 = 1'b1;
    if (o == 14) ihl_bytes = {b[3:0], 2'b00};
    if (o == 17) total_len = hdr_word[15:0];
    if (o == 21 && (hdr_word[13:0] & FRAG_MASK) != '0) is_fragment = 1'b1;
    if (o == 23) proto_q = b;
    if (o == 29) src_q = hdr_word;
    if (o == 33) dst_q = hdr_word;
    if (o >= 14) begin
      l4base = 14 + ihl_bytes;
      if (o == l4base + 3) ports_q = hdr_word;
      if (o == l4base + 12) l4_len_q = {1'b0, b[7:4], 2'b00};
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    res_t found[2];
    int   n;
    bit   done;
    n = 0;
    done = 1'b0;
    case (ph)
      PH_GLOBAL: begin
        hdr_word = {b, hdr_word[31:8]};
        if (byte_idx == 3 && hdr_word != PCAP_MAGIC) err_q = ST_BAD_MAGIC;
        if (byte_idx == 19) snaplen_q = hdr_word;
        byte_idx++;
        if (byte_idx == 24) begin
          if (err_q == ST_OK && hdr_word != LINKTYPE_ETH) err_q = ST_BAD_LINK;
          ph = (err_q != ST_OK) ? PH_HALTED : PH_REC_HEADER;
          byte_idx = '0;
          hdr_word = '0;
        end
      end
      PH_REC_HEADER: begin
        hdr_word = {b, hdr_word[31:8]};
        if (byte_idx == 11) begin
          if (hdr_word > snaplen_q || hdr_word > MAX_CAPTURE) err_q = ST_CAPLEN;
          else caplen_q = hdr_word[16:0];
        end
        byte_idx++;
        if (byte_idx == 16) begin
          if (rec_number != '1) rec_number++;
          byte_idx = '0;
          hdr_word = '0;
          clear_frame();
          if (err_q != ST_OK) ph = PH_HALTED;
          else if (caplen_q == '0) done = 1'b1;
          else ph = PH_REC_DATA;
        end
      end
      PH_REC_DATA: begin
        take_frame_byte(b);
        byte_idx++;
        if (byte_idx >= caplen_q) done = 1'b1;
      end
      default: ;
    endcase
    if (done) begin
      if (summarise_record(found[n])) n++;
      ph = PH_REC_HEADER;
      byte_idx = '0;
      hdr_word = '0;
    end
    if (last) begin
      found[n] = '0;
      found[n].kind = KIND_STATUS;
      found[n].packet_number = rec_number;
      case (ph)
        PH_GLOBAL:     found[n].status = ST_SHORT_GLOBAL;
        PH_REC_HEADER: found[n].status = ST_OK;
        PH_REC_DATA:   found[n].status = ST_TRUNC;
        default:       found[n].status = err_q;
      endcase
      n++;
      clear_parse();
    end
    if (n > 0) found[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(found[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result item: kind %0d status %0d", kind_o, status_o);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", want.kind, kind_o);
    check_field("packet_number", want.packet_number, packet_number_o);
    check_field("src_ip", want.src_ip, src_ip_o);
    check_field("dst_ip", want.dst_ip, dst_ip_o);
    check_field("src_port", want.src_port, src_port_o);
    check_field("dst_port", want.dst_port, dst_port_o);
    check_field("is_tcp", want.is_tcp, is_tcp_o);
    check_field("payload_offset", want.payload_offset, payload_offset_o);
    check_field("payload_length", want.payload_length, payload_length_o);
    check_field("status", want.status, status_o);
    check_field("last_of_run", want.last_of_run, last_of_run_o);
    if (want.kind == KIND_STATUS) statuses_checked++;
    else summaries_checked++;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none at all
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(50, 200);
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        parse_byte(data_byte_i, last_byte_i);
        bytes_taken++;
      end
      if (out_valid_o && out_ready_i) check_result();
    end
  end

  // Driver
  int unsigned send_gap, send_calm;
  always @(negedge clk_i) begin
    capture_byte_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= nxt.data;
        last_byte_i <= nxt.last;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off on the first result, random stalls otherwise
  int unsigned hold_left, stall_left, recv_calm;
  bit          hold_done;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      held_cycles++;
      out_ready_i <= 1'b0;
    end else if (!hold_done && out_valid_o) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap(recv_calm);
    end
  end

  task automatic put_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic start_file();
    file_bytes.delete();
  endtask

  task automatic add_global_header(logic [31:0] magic, logic [31:0] snap, logic [31:0] link);
    put_le32(magic);
    put_le32(32'h0004_0002);
    put_le32($urandom);
    put_le32($urandom);
    put_le32(snap);
    put_le32(link);
  endtask

  task automatic add_record_header(logic [31:0] caplen);
    put_le32($urandom);
    put_le32($urandom);
    put_le32(caplen);
    put_le32($urandom);
  endtask

  task automatic add_raw_bytes(int unsigned count);
    for (int i = 0; i < count; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic poke(int unsigned off, logic [7:0] v);
    if (off < frame_len) file_bytes[frame_base + off] = v;
  endtask

  task automatic add_ip_record(int unsigned caplen, logic [15:0] ethertype, logic [3:0] ihl,
                               logic [7:0] proto, logic [15:0] frag, logic [3:0] doff);
    logic [15:0] tl;
    tl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(caplen - 14);
    add_record_header(caplen);
    frame_base = file_bytes.size();
    frame_len = caplen;
    add_raw_bytes(caplen);
    poke(12, ethertype[15:8]);
    poke(13, ethertype[7:0]);
    poke(14, {4'($urandom), ihl});
    poke(16, tl[15:8]);
    poke(17, tl[7:0]);
    poke(20, frag[15:8]);
    poke(21, frag[7:0]);
    poke(23, proto);
    poke(14 + 4 * ihl + 12, {doff, 4'($urandom)});
  endtask

  // Queue the first keep bytes of the file (all of them when keep is 0 or too large), the final one marked last
  task automatic end_file(int unsigned keep);
    capture_byte_t it;
    if (keep == 0 || keep > file_bytes.size()) keep = file_bytes.size();
    for (int i = 0; i < keep; i++) begin
      it.data = file_bytes[i];
      it.last = (i == keep - 1);
      pending_bytes.push_back(it);
    end
    queued_bytes += keep;
    files_queued++;
  endtask

  function automatic int unsigned l4_need(bit tcp, logic [3:0] ihl, logic [3:0] doff);
    int unsigned need;
    need = 14 + 4 * ihl + (tcp ? ((4 * doff > 20) ? 4 * doff : 20) : 8);
    return (need < 34) ? 34 : need;
  endfunction

  task automatic add_random_record(logic [31:0] snap);
    int unsigned r, cap;
    bit          tcp;
    logic [3:0]  ihl, doff;
    logic [15:0] ethertype, frag;
    logic [7:0]  proto;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      add_record_header((snap < 65536) ? snap + 1 : 32'd65537);
      add_raw_bytes($urandom_range(0, 6));
      return;
    end
    tcp = $urandom_range(0, 1);
    if (r < 80) begin
      ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
      doff = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
      ethertype = ETHERTYPE_IPV4;
      proto = tcp ? PROTO_TCP : PROTO_UDP;
      r = $urandom_range(0, 9);
      frag = (r < 7) ? 16'h0000 : (r < 9) ? 16'h4000 : 16'($urandom);
      cap = l4_need(tcp, ihl, doff) + $urandom_range(0, 16);
      if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, cap);
      planned_summaries++;
    end else begin
      ihl = 4'($urandom);
      doff = 4'($urandom);
      ethertype = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
      r = $urandom_range(0, 2);
      proto = (r == 0) ? PROTO_TCP : (r == 1) ? PROTO_UDP : 8'($urandom);
      frag = 16'($urandom);
      cap = $urandom_range(0, 70);
    end
    if (cap > snap && $urandom_range(0, 4) != 0) cap = snap;
    add_ip_record(cap, ethertype, ihl, proto, frag, doff);
  endtask

  task automatic add_random_file();
    int unsigned r, nrec;
    logic [31:0] magic, link, snap;
    r = $urandom_range(0, 99);
    magic = (r < 6) ? 32'($urandom) : PCAP_MAGIC;
    link = (r >= 6 && r < 11) ? 32'($urandom_range(0, 300)) : LINKTYPE_ETH;
    r = $urandom_range(0, 99);
    snap = (r < 70) ? 32'd65535 : (r < 85) ? 32'hffff_ffff : 32'($urandom_range(30, 120));
    start_file();
    add_global_header(magic, snap, link);
    nrec = $urandom_range(0, 4);
    repeat (nrec) add_random_record(snap);
    end_file(($urandom_range(0, 3) == 0) ? $urandom_range(1, file_bytes.size()) : 0);
  endtask

  task automatic add_directed_files();
    // short global headers first: each file gives a status, which fills the output
    for (int k = 1; k <= 12; k++) begin
      start_file();
      add_global_header(PCAP_MAGIC, 32'd65535, LINKTYPE_ETH);
      end_file((k < 9) ? 1 : 6 * (k - 8) - 1);
    end
    start_file();
    add_global_header(32'hd4c3_b2a1, 32'd65535, 32'd228);
    add_ip_record(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd5);
    end_file(0);
    start_file();
    add_global_header(PCAP_MAGIC, 32'd65535, 32'd101);
    end_file(0);
    start_file();
    add_global_header(PCAP_MAGIC, 32'd65535, LINKTYPE_ETH);
    end_file(0);
    start_file();
    add_global_header(PCAP_MAGIC, 32'd100, LINKTYPE_ETH);
    add_record_header(32'd101);
    add_raw_bytes(5);
    end_file(0);
    // oversized caplen seen, but the file ends inside the record header
    start_file();
    add_global_header(PCAP_MAGIC, 32'd100, LINKTYPE_ETH);
    add_record_header(32'd200);
    end_file(24 + 14);
    start_file();
    add_global_header(PCAP_MAGIC, 32'd65535, LINKTYPE_ETH);
    add_record_header(32'd65536);
    end_file(0);
    start_file();
    add_global_header(PCAP_MAGIC, 32'hffff_ffff, LINKTYPE_ETH);
    add_record_header(32'd65537);
    end_file(0);
    // largest legal record, truncated early
    start_file();
    add_global_header(PCAP_MAGIC, 32'hffff_ffff, LINKTYPE_ETH);
    add_ip_record(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd5);
    add_record_header(32'd65536);
    add_raw_bytes(10);
    end_file(0);
    start_file();
    add_global_header(PCAP_MAGIC, 32'hffff_ffff, LINKTYPE_ETH);
    add_record_header(32'd0);
    add_ip_record(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h4000, 4'd5);
    add_ip_record(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'h0000, 4'd0);
    add_ip_record(34, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'h0000, 4'd0);
    add_ip_record(33, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'h0000, 4'd0);
    add_ip_record(60, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'h2000, 4'd0);
    add_ip_record(60, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'h0001, 4'd0);
    add_ip_record(60, 16'h86dd, 4'd5, PROTO_UDP, 16'h0000, 4'd0);
    add_ip_record(60, ETHERTYPE_IPV4, 4'd5, 8'd1, 16'h0000, 4'd0);
    add_ip_record(40, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd5);
    add_ip_record(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd0);
    add_ip_record(94, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd15);
    add_ip_record(93, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd15);
    add_ip_record(82, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'h0000, 4'd0);
    add_ip_record(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 4'd5);
    end_file(0);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_start_packet(logic [31:0] v);
    @(negedge clk_i);
    start_packet_we_i <= 1'b1;
    start_packet_i <= v;
    start_packet_q = v;
    @(negedge clk_i);
    start_packet_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] settings[4];
    int unsigned byte_goal, summary_goal;
    start_packet_q = '0;
    clear_parse();
    settings = '{32'hffff_ffff, 32'd3, 32'($urandom_range(1, 8)), 32'd0};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    write_start_packet(32'd0);
    add_directed_files();
    drain();
    foreach (settings[i]) begin
      write_start_packet(settings[i]);
      byte_goal = queued_bytes + BytesPerPhase;
      summary_goal = planned_summaries + SummariesPerPhase;
      while (queued_bytes < byte_goal || planned_summaries < summary_goal) add_random_file();
      drain();
    end
    $display("Checked %0d capture bytes in %0d files: %0d packet summaries, %0d end-of-file items.",
             bytes_taken, files_queued, summaries_checked, statuses_checked);
    $display("start_packet went through 0, ffffffff, 3, %0h and 0; output held off for %0d cycles.",
             settings[2], held_cycles);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $error("run stopped after %0d cycles, %0d results outstanding", cycle_count,
           expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
